### hw/rtl/srr_pkg.sv
// Shared types and codes for the shift/rotate read-modify-write unit.
// Item structs, operation and addressing-mode codes, stage control struct.
// No dependencies.
`default_nettype none

package srr_pkg;

  localparam int ADDR_BITS_DEF = 16;

  // Operation codes
  localparam logic [1:0] OP_ASL = 2'd0;
  localparam logic [1:0] OP_LSR = 2'd1;
  localparam logic [1:0] OP_ROL = 2'd2;
  localparam logic [1:0] OP_ROR = 2'd3;

  // Addressing-mode codes; anything above MODE_ABSX is invalid
  localparam logic [2:0] MODE_ACC  = 3'd0;
  localparam logic [2:0] MODE_ZP   = 3'd1;
  localparam logic [2:0] MODE_ZPX  = 3'd2;
  localparam logic [2:0] MODE_ABS  = 3'd3;
  localparam logic [2:0] MODE_ABSX = 3'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  mode;
    logic [15:0] operand_address;
    logic [7:0]  index_x;
  } srr_in_t;

  typedef struct packed {
    logic [7:0]  result_value;
    logic [15:0] effective_address;
    logic        carry_out;
    logic        zero_out;
    logic        negative_out;
    logic        bad_mode;
  } srr_out_t;

  // Decoded control that travels with an item from address stage to execute
  typedef struct packed {
    logic [1:0] op;
    logic       acc;
    logic       bad;
  } srr_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/shift_rotate_rmw_unit.sv
// Top level of the 8-bit shift/rotate read-modify-write unit.
// Address generation and input handshake; instantiates srr_mem and srr_exec.
// Depends on srr_pkg.
//
//  channel  | ports                          | direction
//  ---------+--------------------------------+----------
//  in       | in_valid, in_stall, in_data    | item in (op, mode, operand, X)
//  out      | out_valid, out_stall, out_data | item out (result, address, flags)
//
// An item is read from memory on its accept edge; from the execute stage registers it is
// shifted, written back and registered for output. One item per cycle is sustained
// while the output is not stalled; the memory read/write port sets that rate. A read
// on the same edge as the previous item's write to that byte is forwarded.
// After reset the memory is swept to zero, one byte a cycle, with in_stall high.
// A stalled output holds the execute stage and with it raises in_stall.
`default_nettype none

module shift_rotate_rmw_unit import srr_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire srr_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output srr_out_t      out_data
);

  logic                 issue;
  srr_ctl_t             ctl;
  logic [15:0]          addr_full;
  logic [ADDR_BITS-1:0] addr;
  logic                 rd_en;
  logic [7:0]           rd_data;
  logic                 wr_en;
  logic [ADDR_BITS-1:0] wr_addr;
  logic [7:0]           wr_data;
  logic                 clr_busy;
  logic                 exec_busy;

  // Decode mode into the effective address; zero page wraps in 8 bits,
  // absolute indexed in 16 bits.
  always_comb begin
    ctl.op  = in_data.op;
    ctl.acc = 1'b0;
    ctl.bad = 1'b0;
    unique case (in_data.mode)
      MODE_ACC: begin
        ctl.acc   = 1'b1;
        addr_full = 16'h0000;
      end
      MODE_ZP: begin
        addr_full = {8'h00, in_data.operand_address[7:0]};
      end
      MODE_ZPX: begin
        addr_full = {8'h00, in_data.operand_address[7:0] + in_data.index_x};
      end
      MODE_ABS: begin
        addr_full = in_data.operand_address;
      end
      MODE_ABSX: begin
        addr_full = in_data.operand_address + {8'h00, in_data.index_x};
      end
      default: begin
        ctl.bad   = 1'b1;
        addr_full = 16'h0000;
      end
    endcase
  end

  // Drop upper address bits; a narrow memory aliases them
  assign addr = addr_full[ADDR_BITS-1:0];

  // Hold the input while sweeping or while the execute stage cannot drain
  assign in_stall = clr_busy || exec_busy;
  assign issue    = in_valid && !in_stall;
  assign rd_en    = issue && !ctl.acc && !ctl.bad;

  srr_mem #(
    .ADDR_BITS (ADDR_BITS)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .clr_busy (clr_busy)
  );

  srr_exec #(
    .ADDR_BITS (ADDR_BITS)
  ) u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue      (issue),
    .issue_ctl  (ctl),
    .issue_addr (addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .busy       (exec_busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

### hw/rtl/srr_mem.sv
// Data memory for the shift/rotate unit: one write and one registered read
// port, same-edge write forwarding, and the clearing sweep after reset.
// Depends on srr_pkg.
`default_nettype none

module srr_mem import srr_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output logic      [7:0]           rd_data,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [7:0]           wr_data,
  output logic                      clr_busy
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [7:0]           mem [DEPTH];
  logic [7:0]           rd_q_r;
  logic                 fwd_hit_r;
  logic [7:0]           fwd_data_r;
  logic                 clr_busy_r;
  logic [ADDR_BITS-1:0] clr_addr_r;
  logic                 we;
  logic [ADDR_BITS-1:0] we_addr;
  logic [7:0]           we_data;

  assign we      = clr_busy_r | wr_en;
  assign we_addr = clr_busy_r ? clr_addr_r : wr_addr;
  assign we_data = clr_busy_r ? 8'h00 : wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[we_addr] <= we_data;
    end
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // A read on the same edge as a write to that byte sees the old value:
  // remember the hit and take the written byte instead.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r  <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      if (rd_en) begin
        fwd_hit_r <= wr_en && (wr_addr == rd_addr);
      end
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (&clr_addr_r) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  assign rd_data  = fwd_hit_r ? fwd_data_r : rd_q_r;
  assign clr_busy = clr_busy_r;

`ifndef NO_ASSERTIONS
  a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !wr_en)
    else $error("item write during clearing sweep");

  a_no_read_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !rd_en)
    else $error("item read during clearing sweep");
`endif

endmodule

`default_nettype wire

### hw/rtl/srr_exec.sv
// Execute stage of the shift/rotate unit: shifter, accumulator and flags,
// memory write-back and the output register.
// Depends on srr_pkg.
`default_nettype none

module srr_exec import srr_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 issue,
  input  wire srr_ctl_t             issue_ctl,
  input  wire logic [ADDR_BITS-1:0] issue_addr,
  input  wire logic [7:0]           rd_data,
  output logic                      wr_en,
  output logic      [ADDR_BITS-1:0] wr_addr,
  output logic      [7:0]           wr_data,
  output logic                      busy,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output srr_out_t                  out_data
);

  // Returns {carry, result}
  function automatic logic [8:0] shift_byte(input logic [1:0] op, input logic [7:0] v,
                                            input logic cin);
    logic [8:0] r;
    case (op)
      OP_ASL:  r = {v[7], v[6:0], 1'b0};
      OP_LSR:  r = {v[0], 1'b0, v[7:1]};
      OP_ROL:  r = {v[7], v[6:0], cin};
      default: r = {v[0], cin, v[7:1]};
    endcase
    return r;
  endfunction

  logic                 s1_valid_r;
  srr_ctl_t             s1_ctl_r;
  logic [ADDR_BITS-1:0] s1_addr_r;
  logic                 s1_fire;
  logic [7:0]           acc_r;
  logic                 carry_r;
  logic                 zero_r;
  logic                 neg_r;
  logic                 out_valid_r;
  srr_out_t             out_data_r;
  logic [7:0]           src;
  logic [8:0]           shifted;
  srr_out_t             out_nxt;

  assign s1_fire = s1_valid_r && (!out_valid_r || !out_stall);
  assign busy    = s1_valid_r && !s1_fire;

  assign src     = s1_ctl_r.acc ? acc_r : rd_data;
  assign shifted = shift_byte(s1_ctl_r.op, src, carry_r);

  always_comb begin
    if (s1_ctl_r.bad) begin
      out_nxt = '{result_value: 8'h00, effective_address: 16'h0000,
                  carry_out: carry_r, zero_out: zero_r, negative_out: neg_r,
                  bad_mode: 1'b1};
    end else begin
      out_nxt = '{result_value: shifted[7:0],
                  effective_address: s1_ctl_r.acc ? 16'h0000 : 16'(s1_addr_r),
                  carry_out: shifted[8], zero_out: (shifted[7:0] == 8'h00),
                  negative_out: shifted[7], bad_mode: 1'b0};
    end
  end

  assign wr_en   = s1_fire && !s1_ctl_r.bad && !s1_ctl_r.acc;
  assign wr_addr = s1_addr_r;
  assign wr_data = shifted[7:0];

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_ctl_r  <= issue_ctl;
      s1_addr_r <= issue_addr;
    end
    if (s1_fire) begin
      out_data_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= 8'h00;
      carry_r     <= 1'b0;
      zero_r      <= 1'b0;
      neg_r       <= 1'b0;
    end else begin
      s1_valid_r <= issue || (s1_valid_r && !s1_fire);
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (s1_fire && !s1_ctl_r.bad) begin
        carry_r <= shifted[8];
        zero_r  <= (shifted[7:0] == 8'h00);
        neg_r   <= shifted[7];
        if (s1_ctl_r.acc) begin
          acc_r <= shifted[7:0];
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_bad_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_ctl_r.bad) |=>
      (acc_r == $past(acc_r)) && (carry_r == $past(carry_r)) &&
      (zero_r == $past(zero_r)) && (neg_r == $past(neg_r)))
    else $error("invalid mode changed architectural state");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.bad_mode) |->
      (out_data_r.zero_out == (out_data_r.result_value == 8'h00)))
    else $error("zero flag disagrees with result");

  a_flags_follow_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> (out_data_r.carry_out == carry_r) && (out_data_r.zero_out == zero_r))
    else $error("reported flags differ from stored flags");
`endif

endmodule

`default_nettype wire
